// ===== rtl/core/fprt_pkg.sv =====
// Shared constants and types for the page replacement tracker.
package fprt_pkg;
  localparam int Processes = 8;
  localparam int Pages = 64;
  localparam int Frames = 32;
  localparam int PageShift = 10;
  localparam int ProcW = $clog2(Processes);
  localparam int PageW = $clog2(Pages);
  localparam int FrameW = $clog2(Frames);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    CMD_NEW = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_ACCESS = 2'd2
  } cmd_t;

  localparam logic [1:0] OUT_DONE = 2'd0;
  localparam logic [1:0] OUT_HIT = 2'd1;
  localparam logic [1:0] OUT_MISS = 2'd2;
  localparam logic [1:0] OUT_COMP = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [ProcW-1:0] proc;
    logic [PageW-1:0] page;
  } op_t;
endpackage

// ===== rtl/core/fprt_front.sv =====
// Front end: accepts requests, decodes process and page, queues them.
module fprt_front import fprt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [2:0] in_process_id,
  input  logic [15:0] in_address,
  output logic q_valid,
  input  logic q_pop,
  output op_t q_op
);
  op_t q_r [QDepth];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic push;
  op_t op_in;

  always_comb begin
    op_in.command = in_command;
    op_in.proc = ProcW'(in_process_id);
    op_in.page = PageW'(in_address >> PageShift);
  end

  assign in_stall = (q_cnt_r == 2'(QDepth));
  assign push = in_valid && !in_stall;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_op = q_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[q_wp_r] <= op_in;
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (q_pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ===== rtl/core/fprt_back.sv =====
// Back end: valid table, frame memory search, FIFO replacement, counters.
module fprt_back import fprt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  op_t q_op,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_outcome,
  output logic [31:0] out_access_total,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_compulsory_total
);
  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_WAIT, S_UPDATE, S_OUT} state_t;
  state_t state_r;
  logic [Pages-1:0] valid_r [Processes];
  logic [FrameW-1:0] ptr_r [Processes];
  logic [ProcW-1:0] cur_r;
  logic [PageW-1:0] frame_mem [Processes*Frames];
  logic [PageW-1:0] rd_r;
  logic [FrameW:0] k_r;
  logic found_r, hold_r;
  logic [PageW-1:0] page_r;
  logic [ProcW-1:0] proc_r;
  logic [31:0] acc_r, hit_r, miss_r, comp_r;
  logic [1:0] outc_r;
  logic out_valid_r;
  logic rd_en;
  logic [ProcW+FrameW-1:0] rd_addr;

  assign out_valid = out_valid_r;
  assign out_outcome = outc_r;
  assign out_access_total = acc_r;
  assign out_hit_total = hit_r;
  assign out_miss_total = miss_r;
  assign out_compulsory_total = comp_r;
  assign q_pop = (state_r == S_IDLE) && q_valid && !(out_valid_r && out_stall);
  assign rd_en = (state_r == S_SEARCH);
  assign rd_addr = {proc_r, k_r[FrameW-1:0]};

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= frame_mem[rd_addr];
    if (state_r == S_UPDATE && !found_r)
      frame_mem[{proc_r, ptr_r[proc_r]}] <= page_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int p = 0; p < Processes; p++) begin
        valid_r[p] <= '0;
        ptr_r[p] <= '0;
      end
      cur_r <= '0;
      acc_r <= '0; hit_r <= '0; miss_r <= '0; comp_r <= '0;
      out_valid_r <= 1'b0;
      outc_r <= OUT_DONE;
      k_r <= '0; found_r <= 1'b0; hold_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            page_r <= q_op.page;
            proc_r <= cur_r;
            outc_r <= OUT_DONE;
            case (q_op.command)
              CMD_NEW: begin
                valid_r[q_op.proc] <= '0;
                out_valid_r <= 1'b1;
              end
              CMD_SWITCH: begin
                cur_r <= q_op.proc;
                out_valid_r <= 1'b1;
              end
              CMD_ACCESS: begin
                acc_r <= acc_r + 32'd1;
                k_r <= '0;
                hold_r <= 1'b0;
                if (!valid_r[cur_r][q_op.page]) begin
                  found_r <= 1'b0;
                  outc_r <= OUT_COMP;
                  state_r <= S_UPDATE;
                end else begin
                  state_r <= S_SEARCH;
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_SEARCH: begin
          if (hold_r && rd_r == page_r) found_r <= 1'b1;
          else if (k_r == '0) found_r <= 1'b0;
          hold_r <= 1'b1;
          k_r <= k_r + 1'b1;
          if (k_r == (FrameW+1)'(Frames-1)) state_r <= S_WAIT;
        end
        S_WAIT: begin
          if ((hold_r && rd_r == page_r) || found_r) begin
            found_r <= 1'b1;
            outc_r <= OUT_HIT;
          end else begin
            found_r <= 1'b0;
            outc_r <= OUT_MISS;
          end
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          if (found_r) begin
            hit_r <= hit_r + 32'd1;
          end else begin
            miss_r <= miss_r + 32'd1;
            if (outc_r == OUT_COMP) begin
              comp_r <= comp_r + 32'd1;
              valid_r[proc_r][page_r] <= 1'b1;
            end
            ptr_r[proc_r] <= (ptr_r[proc_r] == FrameW'(Frames-1)) ? '0
                                                                   : ptr_r[proc_r] + 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!(out_valid_r && out_stall)) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/fifo_page_replacement_tracker_unit.sv =====
// Top level of the FIFO page replacement tracker.
// Input channel: in_valid/in_stall carry a request of command, process id and
// address. Command new clears a process's page valid bits, switch selects the
// current process, access looks up page address >> 10 in the current process.
// Result channel: out_valid/out_stall carry the outcome (done, hit, miss,
// compulsory miss) and four running 32-bit wrapping counters.
// A two-entry request queue decouples the front end from the back end.
// out_valid rises once the request is dequeued for new and switch; a compulsory
// miss then passes an update and an output state, and other accesses pass a
// search state that reads the frames of the process from the frame memory one
// per cycle, then a check, an update and an output state.
// Throughput: one new or switch per cycle while out_stall does not hold a
// result; a new request waits until an access has left the output state.
// Reset (rst_n low, synchronous) clears the valid bits, FIFO pointers,
// current process and counters; the frame memory needs no clearing since
// frames past a FIFO pointer stay unwritten only until it first wraps, and a
// valid page can leave the frames only after that wrap.
// A stalled result holds its value; the back end waits for it to drain and
// the queue fills, then in_stall rises.
module fifo_page_replacement_tracker_unit import fprt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [2:0] in_process_id,
  input  logic [15:0] in_address,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_outcome,
  output logic [31:0] out_access_total,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_compulsory_total
);
  logic q_valid, q_pop;
  op_t q_op;

  fprt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_process_id,
    .in_address, .q_valid, .q_pop, .q_op
  );

  fprt_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_op, .out_valid, .out_stall,
    .out_outcome, .out_access_total, .out_hit_total, .out_miss_total,
    .out_compulsory_total
  );
endmodule

// ===== test/tb_top.sv =====
// Testbench for the FIFO page replacement tracker: random and directed requests, scoreboard check.
module tb_top import fprt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] outcome;
    logic [31:0] accesses;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] compulsory;
  } paging_result_t;

  class paging_scoreboard;
    bit page_valid[Processes][Pages];
    logic [PageW-1:0] frame_page[Processes][Frames];
    logic [FrameW-1:0] fifo_ptr[Processes];
    logic [ProcW-1:0] cur_proc;
    logic [31:0] n_access, n_hit, n_miss, n_comp;
    paging_result_t pending[$];
    int mismatches;

    function new();
      foreach (page_valid[p, g]) page_valid[p][g] = 0;
      foreach (frame_page[p, f]) frame_page[p][f] = '0;
      foreach (fifo_ptr[p]) fifo_ptr[p] = '0;
      cur_proc = '0;
      n_access = '0;
      n_hit = '0;
      n_miss = '0;
      n_comp = '0;
      mismatches = 0;
    endfunction

    function void load_page(logic [PageW-1:0] page);
      frame_page[cur_proc][fifo_ptr[cur_proc]] = page;
      fifo_ptr[cur_proc] = fifo_ptr[cur_proc] + 1'b1;
    endfunction

    function void note_request(logic [1:0] cmd, logic [2:0] pid, logic [15:0] addr);
      paging_result_t r;
      logic [PageW-1:0] page;
      bit held;
      r.outcome = OUT_DONE;
      page = addr[PageShift +: PageW];
      held = 0;
      case (cmd)
        CMD_NEW: begin
          for (int g = 0; g < Pages; g++) page_valid[pid][g] = 0;
        end
        CMD_SWITCH: begin
          cur_proc = pid;
        end
        CMD_ACCESS: begin
          n_access++;
          if (!page_valid[cur_proc][page]) begin
            n_miss++;
            n_comp++;
            load_page(page);
            page_valid[cur_proc][page] = 1;
            r.outcome = OUT_COMP;
          end else begin
            for (int f = 0; f < Frames; f++)
              if (frame_page[cur_proc][f] == page) held = 1;
            if (held) begin
              n_hit++;
              r.outcome = OUT_HIT;
            end else begin
              n_miss++;
              load_page(page);
              r.outcome = OUT_MISS;
            end
          end
        end
        default: ;
      endcase
      r.accesses = n_access;
      r.hits = n_hit;
      r.misses = n_miss;
      r.compulsory = n_comp;
      pending.push_back(r);
    endfunction

    function void check_result(paging_result_t got);
      paging_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result outcome=%0d", got.outcome);
        return;
      end
      exp = pending.pop_front();
      if (got.outcome !== exp.outcome || got.accesses !== exp.accesses ||
          got.hits !== exp.hits || got.misses !== exp.misses ||
          got.compulsory !== exp.compulsory) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                   exp.outcome, exp.accesses, exp.hits, exp.misses, exp.compulsory,
                   got.outcome, got.accesses, got.hits, got.misses, got.compulsory);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic [2:0] in_process_id;
  logic [15:0] in_address;
  logic out_valid, out_stall;
  logic [1:0] out_outcome;
  logic [31:0] out_access_total, out_hit_total, out_miss_total, out_compulsory_total;

  paging_scoreboard sb = new();
  bit calm;
  int working_set;
  int stall_left;

  fifo_page_replacement_tracker_unit u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  task automatic send_request(logic [1:0] cmd, logic [2:0] pid, logic [15:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_process_id <= pid;
    in_address <= addr;
    forever begin
      @(negedge clk);
      if (!in_stall) begin
        sb.note_request(cmd, pid, addr);
        @(posedge clk);
        break;
      end
    end
  endtask

  task automatic send_access(int page);
    send_request(CMD_ACCESS, 3'($urandom), {6'(page), 10'($urandom)});
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) send_access($urandom_range(0, working_set - 1));
    else if (pick < 88) send_request(CMD_SWITCH, 3'($urandom), 16'($urandom));
    else if (pick < 94) begin
      working_set = $urandom_range(4, 64);
      send_request(CMD_NEW, 3'($urandom), 16'($urandom));
    end else if (pick < 97) send_access($urandom_range(0, 63));
    else send_request(CMD_UNUSED, 3'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_outcome, out_access_total, out_hit_total,
                        out_miss_total, out_compulsory_total});
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_NEW;
    in_process_id = '0;
    in_address = '0;
    calm = 0;
    working_set = 40;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(CMD_ACCESS, 3'd0, 16'h0000);
    send_request(CMD_ACCESS, 3'd0, 16'h03FF);
    send_request(CMD_ACCESS, 3'd0, 16'hFFFF);
    send_request(CMD_ACCESS, 3'd7, 16'hFC00);
    send_request(CMD_UNUSED, 3'd7, 16'hFFFF);
    send_request(CMD_SWITCH, 3'd7, 16'hFFFF);
    send_request(CMD_ACCESS, 3'd0, 16'h0400);
    send_request(CMD_NEW, 3'd0, 16'h0000);
    send_request(CMD_ACCESS, 3'd0, 16'h0400);
    send_request(CMD_NEW, 3'd7, 16'h0000);
    send_request(CMD_ACCESS, 3'd0, 16'h0400);
    send_request(CMD_SWITCH, 3'd0, 16'h0000);
    send_request(CMD_ACCESS, 3'd5, 16'h0000);
    send_request(CMD_ACCESS, 3'd0, 16'h5555);
    send_request(CMD_ACCESS, 3'd2, 16'hAAAA);
    send_request(CMD_SWITCH, 3'd3, 16'h0000);
    for (int i = 0; i < 800; i++) begin
      if (i == 700) calm = 1;
      send_random();
    end
    in_valid <= 1'b0;
    fork
      wait (sb.pending.size() == 0);
      repeat (200000) @(posedge clk);
    join_any
    disable fork;
    repeat (60) @(posedge clk);
    if (sb.pending.size() == 0 && sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
